// ===== rtl/ring_deque_fixed_core_assert.svh =====
// assertion macros for the ring deque core
// no dependencies; taken in by the files that assert
`ifndef RING_DEQUE_FIXED_CORE_ASSERT_SVH
`define RING_DEQUE_FIXED_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define RDQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define RDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rdq_pkg.sv =====
// shared types and constants of the ring deque core
// no dependencies
`timescale 1ns / 1ps

package rdq_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int WORD_BITS_DEF = 64;

	localparam int OPCODE_W = 3;
	localparam int DATA_W   = 64;
	localparam int POS_W    = 10;
	localparam int LEN_W    = 11;
	localparam int STATUS_W = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_READ_AT    = 3'd4,
		OP_WRITE_AT   = 3'd5,
		OP_RESIZE     = 3'd6
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

// ===== rtl/rdq_ram.sv =====
// ring store: single write port, single registered read port
// depends on nothing but its parameters
`timescale 1ns / 1ps

module rdq_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port: rdata is updated only while re is high
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/ring_deque_fixed_core.sv =====
// ring deque core: double-ended queue of words held in one ring memory
// depends on rdq_pkg, rdq_ram and ring_deque_fixed_core_assert.svh
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  command  | start, accepted if !busy  | opcode, data_word, position, target_length
//  result   | done, one-cycle strobe    | read_word, status, length, is_empty
//
// each command beat: the accept cycle in S_IDLE issues the memory read, then S_EXEC
// decides, writes the memory and registers the result (done follows)
// a growing resize then goes on in S_FILL, zero-filling new slots one slot a cycle
// through the single write port of the ring memory
// reset clears head pointer, count, state and done; the ring memory is not cleared
// the receiver cannot stall: each result beat is shown for exactly one cycle
`timescale 1ns / 1ps
`include "ring_deque_fixed_core_assert.svh"

module ring_deque_fixed_core
	import rdq_pkg::*;
#(
	parameter int CAPACITY  = CAPACITY_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OPCODE_W-1:0] opcode,
	input  logic [DATA_W-1:0]   data_word,
	input  logic [POS_W-1:0]    position,
	input  logic [LEN_W-1:0]    target_length,
	output logic                done,
	output logic [DATA_W-1:0]   read_word,
	output logic [STATUS_W-1:0] status,
	output logic [LEN_W-1:0]    length,
	output logic                is_empty
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = SLOT_W + 1;
	// width wide enough for both the count and an incoming target length
	localparam int CMP_W  = (CNT_W > LEN_W) ? CNT_W : LEN_W;
	localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_FILL = 3'b100
	} state_t;

	state_t state_q, state_nxt;

	// queue state
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  count_q;

	// command beat held for the decide cycle
	opcode_t              op_q;
	logic [WORD_BITS-1:0] word_q;
	logic [POS_W-1:0]     pos_q;
	logic [LEN_W-1:0]     target_q;

	// zero-fill walk for a growing resize
	logic [CMP_W-1:0] fill_q;

	// result registers
	logic                done_q;
	logic [DATA_W-1:0]   read_word_q;
	status_t             status_q;
	logic [LEN_W-1:0]    length_q;
	logic                is_empty_q;

	// memory port
	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic                 mem_re;
	logic [SLOT_W-1:0]    mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;
	logic [SLOT_W-1:0]    rd_off;

	// decide-cycle results
	status_t           ex_status;
	logic [SLOT_W-1:0] ex_head;
	logic [CNT_W-1:0]  ex_count;
	logic              ex_use_rd;
	logic              ex_we;
	logic [SLOT_W-1:0] ex_waddr;
	logic              ex_fill;

	logic              accept;
	logic              fill_last;
	logic              cnt_full;
	logic              cnt_zero;
	logic              cnt_one;
	logic [CMP_W-1:0]  count_ext;
	logic [CMP_W-1:0]  target_ext;
	logic [CMP_W-1:0]  fill_inc;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	assign cnt_full   = (count_q == CNT_FULL);
	assign cnt_zero   = (count_q == '0);
	assign cnt_one    = (count_q == CNT_ONE);
	assign count_ext  = CMP_W'(count_q);
	assign target_ext = CMP_W'(target_q);
	assign fill_inc   = fill_q + CMP_W'(1);
	assign fill_last  = (fill_inc == target_ext);

	// the read is issued straight from the command beat, so data is ready
	// in the decide cycle; head and count are already settled by then
	always_comb begin
		case (opcode_t'(opcode))
			OP_POP_BACK: rd_off = SLOT_W'(count_q - CNT_ONE);
			OP_READ_AT:  rd_off = SLOT_W'(position);
			default:     rd_off = '0;
		endcase
	end

	assign mem_re    = accept;
	assign mem_raddr = head_q + rd_off;

	// decide: status, new head and count, memory write
	always_comb begin
		ex_status = ST_OK;
		ex_head   = head_q;
		ex_count  = count_q;
		ex_use_rd = 1'b0;
		ex_we     = 1'b0;
		ex_waddr  = head_q;
		ex_fill   = 1'b0;
		case (op_q)
			OP_PUSH_FRONT: begin
				if (cnt_full) begin
					ex_status = ST_FULL;
				end else begin
					ex_head  = head_q - SLOT_W'(1);
					ex_waddr = head_q - SLOT_W'(1);
					ex_we    = 1'b1;
					ex_count = count_q + CNT_ONE;
				end
			end
			OP_PUSH_BACK: begin
				if (cnt_full) begin
					ex_status = ST_FULL;
				end else begin
					ex_waddr = head_q + SLOT_W'(count_q);
					ex_we    = 1'b1;
					ex_count = count_q + CNT_ONE;
				end
			end
			OP_POP_FRONT, OP_POP_BACK: begin
				if (cnt_zero) begin
					ex_status = ST_EMPTY;
				end else begin
					ex_use_rd = 1'b1;
					ex_count  = count_q - CNT_ONE;
					// last element gone: head returns to slot zero
					if (cnt_one) begin
						ex_head = '0;
					end else if (op_q == OP_POP_FRONT) begin
						ex_head = head_q + SLOT_W'(1);
					end
				end
			end
			OP_READ_AT, OP_WRITE_AT: begin
				if (cnt_zero) begin
					ex_status = ST_EMPTY;
				end else if (CMP_W'(pos_q) >= count_ext) begin
					ex_status = ST_RANGE;
				end else if (op_q == OP_READ_AT) begin
					ex_use_rd = 1'b1;
				end else begin
					ex_waddr = head_q + SLOT_W'(pos_q);
					ex_we    = 1'b1;
				end
			end
			OP_RESIZE: begin
				if (target_ext > CAP_C) begin
					ex_status = ST_FULL;
				end else if (target_ext < count_ext) begin
					ex_count = CNT_W'(target_q);
					if (target_q == '0) begin
						ex_head = '0;
					end
				end else if (target_ext > count_ext) begin
					ex_fill = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// memory write mux: decide cycle or zero-fill walk
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ex_waddr;
		mem_wdata = word_q;
		case (state_q)
			S_EXEC: begin
				mem_we = ex_we;
			end
			S_FILL: begin
				mem_we    = 1'b1;
				mem_waddr = head_q + SLOT_W'(fill_q);
				mem_wdata = '0;
			end
			default: begin
			end
		endcase
	end

	rdq_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = ex_fill ? S_FILL : S_IDLE;
			end
			S_FILL: begin
				if (fill_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= 1'b0;
			case (state_q)
				S_EXEC: begin
					head_q  <= ex_head;
					count_q <= ex_count;
					done_q  <= !ex_fill;
				end
				S_FILL: begin
					if (fill_last) begin
						count_q <= CNT_W'(target_q);
						done_q  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// command beat capture, fill walk and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= opcode_t'(opcode);
			word_q   <= data_word[WORD_BITS-1:0];
			pos_q    <= position;
			target_q <= target_length;
		end
		case (state_q)
			S_EXEC: begin
				fill_q      <= count_ext;
				read_word_q <= ex_use_rd ? DATA_W'(mem_rdata) : '0;
				status_q    <= ex_status;
				length_q    <= LEN_W'(CMP_W'(ex_count));
				is_empty_q  <= (ex_count == '0);
			end
			S_FILL: begin
				fill_q <= fill_inc;
				if (fill_last) begin
					read_word_q <= '0;
					status_q    <= ST_OK;
					length_q    <= target_q;
					is_empty_q  <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign read_word = read_word_q;
	assign status    = status_q;
	assign length    = length_q;
	assign is_empty  = is_empty_q;

	// count never passes the ring size
	`RDQ_ASSERT_NOW(a_count_cap, clk, arst_n, 1'b1, count_q <= CNT_FULL, "count beyond capacity")
	// an empty queue always has its head at slot zero
	`RDQ_ASSERT_NOW(a_empty_head, clk, arst_n, cnt_zero, head_q == '0, "empty queue with head off zero")
	// the empty flag of a result beat agrees with the stored count
	`RDQ_ASSERT_NOW(a_empty_flag, clk, arst_n, done, is_empty == cnt_zero, "empty flag disagrees with count")
	// an accepted command beat holds the block busy
	`RDQ_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy, "accepted beat left block idle")
	// result beats never come back to back
	`RDQ_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe held for two cycles")

endmodule
